// ===== design/ibpc_pkg.sv =====
package ibpc_pkg;

  // Configuration port.
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_LIMIT  = 2'd2;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

  // Pixel and result fields.
  localparam int LIMIT_W = 4;
  localparam int PIX_W   = 32;
  localparam int RGB_W   = 24;
  localparam int POS_W   = 11;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 4'd4;
  localparam logic [LIMIT_W-1:0] NEIGHBOR_COUNT = 4'd8;
  localparam logic [RGB_W-1:0]   WHITE_RGB      = 24'hFF_FFFF;

  // Control word that travels with an item from the position logic to the filter.
  typedef struct packed {
    logic             emit;       // the item releases a finished pixel
    logic             pixel;      // the item carries a pixel (not a flush)
    logic             interior;   // the released pixel lies off the image border
    logic             frame_end;  // the released pixel is the bottom right one
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
  } ibpc_tag_t;

endpackage

// ===== design/ibpc_ram.sv =====
module ibpc_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/ibpc_ctrl.sv =====
module ibpc_ctrl #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int LD = MAX_WIDTH + 1,
  localparam int SW = $clog2(LD)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ibpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ibpc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          accept,
  input  logic                          command,
  output logic                          restart,
  output logic [ibpc_pkg::LIMIT_W-1:0]   limit,
  output logic                          line_we,
  output logic [SW-1:0]                 wr_slot,
  output logic [SW-1:0]                 rd_slot,
  output logic [CW-1:0]                 store_col,
  output ibpc_pkg::ibpc_tag_t            tag
);

  import ibpc_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int PW = $clog2(MAX_WIDTH + 2);

  logic [CFG_W-1:0]   width_r;
  logic [CFG_W-1:0]   height_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [CW-1:0]      icol_r;
  logic [RW-1:0]      irow_r;
  logic [CW-1:0]      ocol_r;
  logic [RW-1:0]      orow_r;
  logic [PW-1:0]      pend_r;
  logic [SW-1:0]      ws_r;

  logic [WW-1:0] wu;
  logic [HW-1:0] hu;
  logic          icol_last, irow_last, ocol_last, orow_last, ws_last;
  logic          emit_pix, emit, interior;
  logic [SW:0]   slot_sum;

  // Frame size as used: zero counts as one, large values clip at the maximum.
  always_comb begin
    if (width_r == '0) begin
      wu = WW'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      wu = WW'(MAX_WIDTH);
    end else begin
      wu = WW'(width_r);
    end
    if (height_r == '0) begin
      hu = HW'(1);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      hu = HW'(MAX_HEIGHT);
    end else begin
      hu = HW'(height_r);
    end
  end

  always_comb begin
    icol_last = (WW'(icol_r) + WW'(1)) == wu;
    irow_last = (HW'(irow_r) + HW'(1)) == hu;
    ocol_last = (WW'(ocol_r) + WW'(1)) == wu;
    orow_last = (HW'(orow_r) + HW'(1)) == hu;
    ws_last   = 32'(ws_r) == LD - 1;
    emit_pix  = 32'(pend_r) >= 32'(wu) + 32'd1;
    emit      = command ? (pend_r != '0) : emit_pix;
    interior  = (wu >= WW'(3)) && (hu >= HW'(3)) && (ocol_r != '0) && (orow_r != '0) &&
                (32'(ocol_r) + 32'd2 <= 32'(wu)) && (32'(orow_r) + 32'd2 <= 32'(hu));
    // Oldest pending slot, write slot minus pending count around the ring.
    slot_sum  = (SW+1)'(ws_r) + (SW+1)'(LD) - (SW+1)'(pend_r);
  end

  assign rd_slot   = (slot_sum >= (SW+1)'(LD)) ? SW'(slot_sum - (SW+1)'(LD)) : SW'(slot_sum);
  assign wr_slot   = ws_r;
  assign line_we   = accept && !command;
  assign store_col = icol_r;
  assign limit     = limit_r;
  assign restart   = cfg_we && (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT);

  always_comb begin
    tag.emit      = emit;
    tag.pixel     = !command;
    tag.interior  = interior;
    tag.frame_end = ocol_last && orow_last;
    tag.col       = POS_W'(ocol_r);
    tag.row       = POS_W'(orow_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      limit_r  <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data;
        CFG_IMAGE_HEIGHT: height_r <= cfg_data;
        CFG_WHITE_LIMIT:  limit_r  <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // The oldest pending position trails the input position by the pending count.
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      icol_r <= '0;
      irow_r <= '0;
      ocol_r <= '0;
      orow_r <= '0;
      pend_r <= '0;
      ws_r   <= '0;
    end else if (accept) begin
      if (!command) begin
        ws_r   <= ws_last ? '0 : ws_r + 1'b1;
        icol_r <= icol_last ? '0 : icol_r + 1'b1;
        if (icol_last) begin
          irow_r <= irow_last ? '0 : irow_r + 1'b1;
        end
        if (!emit_pix) begin
          pend_r <= pend_r + 1'b1;
        end
      end else if (pend_r != '0) begin
        pend_r <= pend_r - 1'b1;
      end
      if (emit) begin
        ocol_r <= ocol_last ? '0 : ocol_r + 1'b1;
        if (ocol_last) begin
          orow_r <= orow_last ? '0 : orow_r + 1'b1;
        end
      end
    end
  end

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pend_r) <= 32'(wu) + 32'd1)
    else $error("pending count exceeds one row plus one pixel");

  a_empty_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r == '0) |-> (ocol_r == icol_r && orow_r == irow_r))
    else $error("oldest pending position differs from input position while empty");

endmodule

// ===== design/ibpc_filter.sv =====
module ibpc_filter #(
  parameter int MAX_WIDTH = 2048,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       restart,
  input  logic                       accept,
  input  logic                       in_black,
  input  logic [CW-1:0]              in_col,
  input  ibpc_pkg::ibpc_tag_t         in_tag,
  input  logic [ibpc_pkg::LIMIT_W-1:0] limit,
  input  logic [ibpc_pkg::PIX_W-1:0]   line_q,
  output logic                       in_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ibpc_pkg::PIX_W-1:0]   out_pix,
  output logic [ibpc_pkg::POS_W-1:0]   out_col,
  output logic [ibpc_pkg::POS_W-1:0]   out_row,
  output logic                       out_last
);

  import ibpc_pkg::*;

  logic            s1_vld_r;
  ibpc_tag_t       s1_tag_r;
  logic            s1_black_r;
  logic [CW-1:0]   s1_col_r;
  logic [8:0]      window_r;
  logic            out_vld_r;
  logic [PIX_W-1:0] out_pix_r;
  logic [POS_W-1:0] out_col_r;
  logic [POS_W-1:0] out_row_r;
  logic            out_last_r;

  logic [1:0]       above;
  logic [1:0]       store_wd;
  logic             store_we;
  logic             out_free, drain, whiten;
  logic [8:0]       win_nxt;
  logic [LIMIT_W-1:0] black_nb, white_cnt;

  // Black flags of the two rows above, per column.
  ibpc_ram #(.DEPTH(MAX_WIDTH), .WIDTH(2)) u_store (
    .clk     (clk),
    .we      (store_we),
    .wr_addr (s1_col_r),
    .wr_data (store_wd),
    .rd_en   (accept),
    .rd_addr (in_col),
    .rd_data (above)
  );

  assign out_free = !out_vld_r || out_ready;
  assign drain    = s1_vld_r && out_free;
  assign in_ready = !s1_vld_r || out_free;
  assign store_we = drain && s1_tag_r.pixel;
  assign store_wd = {above[0], s1_black_r};
  assign win_nxt  = {window_r[5:0], above[1], above[0], s1_black_r};

  always_comb begin
    black_nb = '0;
    for (int k = 0; k < 9; k++) begin
      if (k != 4) begin
        black_nb = black_nb + LIMIT_W'(win_nxt[k]);
      end
    end
    white_cnt = NEIGHBOR_COUNT - black_nb;
    whiten    = s1_tag_r.pixel && s1_tag_r.interior && win_nxt[4] && (white_cnt >= limit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (accept) begin
      s1_vld_r <= 1'b1;
    end else if (drain) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_tag_r   <= in_tag;
      s1_black_r <= in_black;
      s1_col_r   <= in_col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      window_r <= '0;
    end else if (store_we) begin
      window_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= s1_vld_r && s1_tag_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (drain && s1_tag_r.emit) begin
      out_pix_r  <= {line_q[PIX_W-1:RGB_W], whiten ? WHITE_RGB : line_q[RGB_W-1:0]};
      out_col_r  <= s1_tag_r.col;
      out_row_r  <= s1_tag_r.row;
      out_last_r <= s1_tag_r.frame_end;
    end
  end

  assign out_valid = out_vld_r;
  assign out_pix   = out_pix_r;
  assign out_col   = out_col_r;
  assign out_row   = out_row_r;
  assign out_last  = out_last_r;

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && out_vld_r && !out_ready) |-> !in_ready)
    else $error("item taken while the pipeline is full and the output stalls");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(s1_vld_r && s1_tag_r.emit))
    else $error("result appeared without an emitting item in the first stage");

endmodule

// ===== design/isolated_black_pixel_cleaner_top.sv =====
// Isolated black pixel cleaner. RGBA pixels arrive in raster order, one item per
// clock, and leave delayed by one row plus one pixel. A pixel is black when red,
// green and blue are all zero; an interior black pixel whose count of non-black
// neighbors in the 3x3 window reaches white_count_limit leaves as white with its
// alpha kept, and every other pixel leaves unchanged. Border pixels, and all pixels
// of frames narrower or shorter than three, are never whitened. After reset or a
// write of image_width or image_height the first image_width + 1 pixels give no
// result; from then on each pixel item releases the oldest pending pixel. A flush
// item (in_tuser high) releases one pending pixel unchanged, or nothing if none is
// pending, so image_width + 1 flushes drain a frame. The block takes one item per
// clock and keeps that rate as long as out_tready stays high; a result passes the
// first stage and then the output register. The rate is set by the pixel delay line,
// one RAM of MAX_WIDTH + 1 words that is written once per pixel item and read once
// per item, next to a MAX_WIDTH by 2 RAM with the black flags of the two rows above.
// Neither RAM is cleared after reset, so the block is ready at once. The user must
// write configuration only while no item is in flight; the block does not enforce it.
module isolated_black_pixel_cleaner_top #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // red_in, green_in, blue_in, alpha_in
  input  logic                          in_tuser,   // command: 0 pixel, 1 flush
  // Result channel.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [55:0]                   out_tdata,  // red_out, green_out, blue_out,
                                                    // alpha_out, out_column, out_row, pad
  output logic                          out_tlast,  // frame_end
  // Configuration port.
  input  logic                          cfg_we,
  input  logic [ibpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ibpc_pkg::CFG_W-1:0]     cfg_data
);

  import ibpc_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int SW = $clog2(MAX_WIDTH + 1);

  logic               accept;
  logic               restart;
  logic               line_we;
  logic               in_black;
  logic [LIMIT_W-1:0] limit;
  logic [SW-1:0]      wr_slot, rd_slot;
  logic [CW-1:0]      store_col;
  logic [PIX_W-1:0]   line_q;
  logic [PIX_W-1:0]   out_pix;
  logic [POS_W-1:0]   out_col, out_row;
  ibpc_tag_t          tag;

  assign accept   = in_tvalid && in_tready;
  assign in_black = in_tdata[RGB_W-1:0] == '0;

  // Frame position, pending count and ring slots of the delay line.
  ibpc_ctrl #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .command   (in_tuser),
    .restart   (restart),
    .limit     (limit),
    .line_we   (line_we),
    .wr_slot   (wr_slot),
    .rd_slot   (rd_slot),
    .store_col (store_col),
    .tag       (tag)
  );

  // Pending pixels, written at the ring's head and read at its tail.
  ibpc_ram #(.DEPTH(MAX_WIDTH + 1), .WIDTH(PIX_W)) u_line (
    .clk     (clk),
    .we      (line_we),
    .wr_addr (wr_slot),
    .wr_data (in_tdata),
    .rd_en   (accept),
    .rd_addr (rd_slot),
    .rd_data (line_q)
  );

  // Window update, whitening decision and output register.
  ibpc_filter #(.MAX_WIDTH(MAX_WIDTH)) u_filter (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (restart),
    .accept    (accept),
    .in_black  (in_black),
    .in_col    (store_col),
    .in_tag    (tag),
    .limit     (limit),
    .line_q    (line_q),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pix   (out_pix),
    .out_col   (out_col),
    .out_row   (out_row),
    .out_last  (out_tlast)
  );

  assign out_tdata = {2'b00, out_row, out_col, out_pix};

endmodule
